### rtl/rc4_stream_cipher_assert.svh
// assertion macros used by the rc4 rtl top level
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RC4_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rc4_pkg.sv
// types and constants for the rc4 stream cipher
package rc4_pkg;

	localparam int KEY_MAX   = 16;
	localparam int KEY_IDX_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

	localparam logic [63:0] KEY_LOW_RST  = 64'h0000_0005_7163_9A0E;
	localparam logic [63:0] KEY_HIGH_RST = 64'h0;

	// sequencer states, one-hot
	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_KINIT = 11'b000_0000_0010,
		ST_KRDA  = 11'b000_0000_0100,
		ST_KRDB  = 11'b000_0000_1000,
		ST_KWRA  = 11'b000_0001_0000,
		ST_KWRB  = 11'b000_0010_0000,
		ST_PRDI  = 11'b000_0100_0000,
		ST_PRDJ  = 11'b000_1000_0000,
		ST_PWRI  = 11'b001_0000_0000,
		ST_PWRJ  = 11'b010_0000_0000,
		ST_POUT  = 11'b100_0000_0000
	} state_t;

	// one read and one write access to the permutation memory
	typedef struct packed {
		logic       rd_en;
		logic [7:0] rd_addr;
		logic       wr_en;
		logic [7:0] wr_addr;
		logic [7:0] wr_data;
	} mem_req_t;

endpackage

### rtl/rc4_stream_cipher.sv
// rc4 stream cipher top level: key registers, sequencer and output register
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    data_byte[7:0], restart
//   out      out  out_valid/out_ready  out_byte[7:0]
//   cfg      in   cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[63:0]
//
// a keyed item holds in_ready low from its accept until the output step loads
// its result, so no new item is taken before the last is through; the memory
// with one read and one write port sets the steps: read s[i] in the accept
// cycle, read s[j], write s[i], write s[j] with the keystream read, then the
// output step. a restart item, or the first after reset, first runs the key
// schedule: fill, read s[a], s[b], write s[a], s[b] per entry, then read s[i].
// reset clears the indices and the keyed flag and loads the reset key; the
// memory is not cleared. a result waiting on out_ready holds the block in
// its last step, while cfg writes are always taken.
`include "rc4_stream_cipher_assert.svh"

module rc4_stream_cipher #(
	parameter int KEY_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int KeyLen = (KEY_BYTES < 1) ? 1 :
		(KEY_BYTES > rc4_pkg::KEY_MAX) ? rc4_pkg::KEY_MAX : KEY_BYTES;
	localparam logic [rc4_pkg::KEY_IDX_W-1:0] KidxLast = rc4_pkg::KEY_IDX_W'(KeyLen - 1);

	rc4_pkg::state_t   state_q;
	rc4_pkg::mem_req_t mem_req;

	logic [63:0]  key_low_q;
	logic [63:0]  key_high_q;
	logic [127:0] key_cat;
	logic [7:0]   key_byte;

	logic [7:0] a_q, b_q, i_q, j_q;
	logic [rc4_pkg::KEY_IDX_W-1:0] kidx_q;
	logic       keyed_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [7:0] data_q, sa_q, si_q;
	logic       byp_q;
	logic [7:0] rd_data;

	logic       in_acc;
	logic       rekey;
	logic [7:0] b_new, j_new, ks_addr, ks_byte;
	logic       out_load;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= rc4_pkg::KEY_LOW_RST;
			key_high_q <= rc4_pkg::KEY_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rc4_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				rc4_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// key byte for the current schedule step
	assign key_cat  = {key_high_q, key_low_q};
	assign key_byte = key_cat[{kidx_q, 3'b000} +: 8];

	// handshake and datapath sums
	assign in_ready = (state_q == rc4_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign rekey    = restart || !keyed_q;
	assign b_new    = b_q + rd_data + key_byte;
	assign j_new    = j_q + rd_data;
	assign ks_addr  = si_q + rd_data;
	assign ks_byte  = byp_q ? si_q : rd_data;
	assign out_load = (state_q == rc4_pkg::ST_POUT) && (!out_valid_q || out_ready);

	// memory access per sequencer step
	always_comb begin
		mem_req = '0;
		case (state_q)
			rc4_pkg::ST_IDLE: begin
				mem_req.rd_en   = in_acc && !rekey;
				mem_req.rd_addr = i_q + 8'd1;
			end
			rc4_pkg::ST_KINIT: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = a_q;
				mem_req.wr_data = a_q;
			end
			rc4_pkg::ST_KRDA: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = a_q;
			end
			rc4_pkg::ST_KRDB: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = b_new;
			end
			rc4_pkg::ST_KWRA: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = a_q;
				mem_req.wr_data = rd_data;
			end
			rc4_pkg::ST_KWRB: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = b_q;
				mem_req.wr_data = sa_q;
			end
			rc4_pkg::ST_PRDI: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = i_q + 8'd1;
			end
			rc4_pkg::ST_PRDJ: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = j_new;
			end
			rc4_pkg::ST_PWRI: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = i_q;
				mem_req.wr_data = rd_data;
			end
			rc4_pkg::ST_PWRJ: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = j_q;
				mem_req.wr_data = si_q;
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = ks_addr;
			end
			default: ;
		endcase
	end

	rc4_sbox u_sbox (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rc4_pkg::ST_IDLE;
			a_q         <= '0;
			b_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			kidx_q      <= '0;
			keyed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rc4_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (rekey) begin
							a_q     <= '0;
							state_q <= rc4_pkg::ST_KINIT;
						end else begin
							i_q     <= i_q + 8'd1;
							state_q <= rc4_pkg::ST_PRDJ;
						end
					end
				end
				rc4_pkg::ST_KINIT: begin
					a_q <= a_q + 8'd1;
					if (a_q == 8'hFF) begin
						b_q     <= '0;
						kidx_q  <= '0;
						state_q <= rc4_pkg::ST_KRDA;
					end
				end
				rc4_pkg::ST_KRDA: state_q <= rc4_pkg::ST_KRDB;
				rc4_pkg::ST_KRDB: begin
					b_q     <= b_new;
					state_q <= rc4_pkg::ST_KWRA;
				end
				rc4_pkg::ST_KWRA: state_q <= rc4_pkg::ST_KWRB;
				rc4_pkg::ST_KWRB: begin
					a_q    <= a_q + 8'd1;
					kidx_q <= (kidx_q == KidxLast) ? '0 : kidx_q + 1'b1;
					if (a_q == 8'hFF) begin
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
						state_q <= rc4_pkg::ST_PRDI;
					end else begin
						state_q <= rc4_pkg::ST_KRDA;
					end
				end
				rc4_pkg::ST_PRDI: begin
					i_q     <= i_q + 8'd1;
					state_q <= rc4_pkg::ST_PRDJ;
				end
				rc4_pkg::ST_PRDJ: begin
					j_q     <= j_new;
					state_q <= rc4_pkg::ST_PWRI;
				end
				rc4_pkg::ST_PWRI: state_q <= rc4_pkg::ST_PWRJ;
				rc4_pkg::ST_PWRJ: state_q <= rc4_pkg::ST_POUT;
				rc4_pkg::ST_POUT: begin
					if (out_load) begin
						state_q <= rc4_pkg::ST_IDLE;
					end
				end
				default: state_q <= rc4_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_q <= data_byte;
		end
		if (state_q == rc4_pkg::ST_KRDB) begin
			sa_q <= rd_data;
		end
		if (state_q == rc4_pkg::ST_PRDJ) begin
			si_q <= rd_data;
		end
		// keystream read collides with the write to s[j]
		if (state_q == rc4_pkg::ST_PWRJ) begin
			byp_q <= (ks_addr == j_q);
		end
		if (out_load) begin
			out_byte_q <= data_q ^ ks_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

	// checks
	`RC4_ASSERT_NEXT(a_rekey_start, in_acc && rekey, state_q == rc4_pkg::ST_KINIT,
		"rekey item did not start the key schedule")
	`RC4_ASSERT_NEXT(a_keyed_sticks, keyed_q, keyed_q, "keyed flag dropped")
	`RC4_ASSERT_NEXT(a_ksa_end, (state_q == rc4_pkg::ST_KWRB) && (a_q == 8'hFF),
		(state_q == rc4_pkg::ST_PRDI) && (i_q == 8'd0) && (j_q == 8'd0),
		"key schedule did not hand over with cleared indices")
	`RC4_ASSERT_NOW(a_wr_states, mem_req.wr_en,
		(state_q == rc4_pkg::ST_KINIT) || (state_q == rc4_pkg::ST_KWRA) ||
		(state_q == rc4_pkg::ST_KWRB) || (state_q == rc4_pkg::ST_PWRI) ||
		(state_q == rc4_pkg::ST_PWRJ),
		"memory write outside a write step")

endmodule

### rtl/rc4_sbox.sv
// 256 x 8 permutation memory, one write and one registered read per cycle
module rc4_sbox (
	input  logic              clk,
	input  rc4_pkg::mem_req_t req,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [256];
	logic [7:0] rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// read port, old data on a same-address write, holds when idle
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
